>>> sv/e2q_pkg.sv
// Package: constants, types and helpers for the Euler angle to quaternion pipeline.
`default_nettype none
package e2q_pkg;
  localparam int unsigned CordicStages = 16;
  localparam int unsigned TableLen = 24;
  localparam int unsigned NumStages = (CordicStages < TableLen) ? CordicStages : TableLen;
  localparam int unsigned AngleW = 24;
  localparam int unsigned QuatW = 16;
  localparam int unsigned CordW = 34;
  localparam int unsigned PhaseTurn = 2949120;
  localparam int unsigned PhaseQuarter = 737280;
  localparam int unsigned PhaseW = 22;
  localparam int unsigned FracW = 20;
  localparam logic [30:0] HalfPiQ30 = 31'd1686629713;
  localparam logic signed [CordW-1:0] GainQ30 = 34'sd652032874;
  localparam int unsigned ProdW = 64;

  typedef logic signed [CordW-1:0] cord_t;
  typedef logic [1:0] quad_t;

  typedef struct packed {
    cord_t x;
    cord_t y;
    cord_t z;
    quad_t q;
  } cord_lane_t;

  function automatic cord_t atan_q30(input logic [4:0] i);
    cord_t r;
    case (i)
      5'd0: r = 34'sd843314856;
      5'd1: r = 34'sd497837829;
      5'd2: r = 34'sd263043836;
      5'd3: r = 34'sd133525158;
      5'd4: r = 34'sd67021686;
      5'd5: r = 34'sd33543515;
      5'd6: r = 34'sd16775850;
      5'd7: r = 34'sd8388437;
      5'd8: r = 34'sd4194282;
      5'd9: r = 34'sd2097149;
      5'd10: r = 34'sd1048575;
      5'd11: r = 34'sd524287;
      5'd12: r = 34'sd262143;
      5'd13: r = 34'sd131071;
      5'd14: r = 34'sd65535;
      5'd15: r = 34'sd32767;
      5'd16: r = 34'sd16383;
      5'd17: r = 34'sd8191;
      5'd18: r = 34'sd4095;
      5'd19: r = 34'sd2047;
      5'd20: r = 34'sd1023;
      5'd21: r = 34'sd511;
      5'd22: r = 34'sd255;
      5'd23: r = 34'sd127;
      default: r = '0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

>>> sv/euler_to_quaternion.sv
// Top level: pipelined Euler angle to quaternion converter.
// Takes one angle triple per cycle and returns one quaternion per beat, while the output is not stalled.
// The pipeline registers are, in order: phase reduction, quadrant split, radian
// product, divide by 45, one CORDIC stage per iteration, quadrant map, two product
// stages, rounding. The whole pipeline advances together; a stall at the output
// holds every stage and the input together with it.
// No state besides the pipeline; no reset-time pass.
`default_nettype none
module euler_to_quaternion (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output logic             stall_o,
  input  wire logic signed [23:0] angle_x_i,
  input  wire logic signed [23:0] angle_y_i,
  input  wire logic signed [23:0] angle_z_i,
  output logic             valid_o,
  input  wire logic        stall_i,
  output logic signed [15:0] quat_x_o,
  output logic signed [15:0] quat_y_o,
  output logic signed [15:0] quat_z_o,
  output logic signed [15:0] quat_w_o
);
  localparam int unsigned N = e2q_pkg::NumStages;
  localparam int unsigned Lat = N + 8;

  logic adv;
  logic [Lat-1:0] vld_q;
  // A valid output beat held by stall freezes the whole pipeline.
  assign adv = !(vld_q[Lat-1] && stall_i);
  assign stall_o = !adv;
  assign valid_o = vld_q[Lat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Lat-2:0], valid_i};
    end
  end

  // Stage 1: reduce each angle into one half-angle turn.
  logic signed [23:0] ang [3];
  logic [e2q_pkg::PhaseW-1:0] r_q [3];
  assign ang[0] = angle_x_i;
  assign ang[1] = angle_y_i;
  assign ang[2] = angle_z_i;

  // Stage 2: quadrant and remainder. Stage 3: remainder to radians. Stage 4: divide.
  e2q_pkg::quad_t q2_q [3];
  logic [e2q_pkg::FracW-1:0] f2_q [3];
  e2q_pkg::quad_t q3_q [3];
  logic [50:0] m3_q [3];
  e2q_pkg::quad_t q4_q [3];
  e2q_pkg::cord_t th_q [3];
  e2q_pkg::cord_lane_t lane_q [3][N+1];

  for (genvar a = 0; a < 3; a++) begin : g_ax
    logic signed [24:0] rs;
    logic [e2q_pkg::PhaseW-1:0] r_d;
    logic [e2q_pkg::PhaseW-1:0] f_d;
    e2q_pkg::quad_t q_d;
    always_comb begin
      rs = 25'(ang[a]);
      // |angle| < 2^23 < 3*turn: at most three adds of one turn.
      if (rs < 0) rs = rs + 25'sd2949120;
      if (rs < 0) rs = rs + 25'sd2949120;
      if (rs < 0) rs = rs + 25'sd2949120;
      if (rs >= 25'sd2949120) rs = rs - 25'sd2949120;
      if (rs >= 25'sd2949120) rs = rs - 25'sd2949120;
      r_d = rs[e2q_pkg::PhaseW-1:0];
    end
    always_comb begin
      if (r_q[a] >= 22'd2211840) begin
        q_d = 2'd3; f_d = r_q[a] - 22'd2211840;
      end else if (r_q[a] >= 22'd1474560) begin
        q_d = 2'd2; f_d = r_q[a] - 22'd1474560;
      end else if (r_q[a] >= 22'd737280) begin
        q_d = 2'd1; f_d = r_q[a] - 22'd737280;
      end else begin
        q_d = 2'd0; f_d = r_q[a];
      end
    end
    // theta = floor((f*HalfPi + 368640)/737280); 737280 = 2^14 * 45.
    // Divide by 45 via reciprocal multiply with exact correction.
    logic [50:0] num;
    logic [36:0] hi;
    logic [36:0] qt;
    logic [42:0] rem;
    logic [36:0] th;
    assign num = 51'(f2_q[a]) * 51'(e2q_pkg::HalfPiQ30) + 51'd368640;
    always_ff @(posedge clk_i) begin
      if (adv) begin
        r_q[a] <= r_d;
        q2_q[a] <= q_d;
        f2_q[a] <= f_d[e2q_pkg::FracW-1:0];
        q3_q[a] <= q2_q[a];
        m3_q[a] <= num;
        q4_q[a] <= q3_q[a];
        th_q[a] <= e2q_pkg::cord_t'(th);
      end
    end
    always_comb begin
      hi = m3_q[a][50:14];
      // floor(hi/45): hi < 2^37; reciprocal estimate then fix.
      qt = 37'((74'(hi) * 74'd3054198966) >> 37);
      rem = 43'(hi) - 43'(qt) * 43'd45;
      th = qt;
      if (rem >= 43'd45) th = qt + 37'd1;
    end
    assign lane_q[a][0] = '{x: e2q_pkg::GainQ30, y: '0,
                            z: th_q[a], q: q4_q[a]};
    for (genvar s = 0; s < N; s++) begin : g_st
      e2q_pkg::cord_lane_t nxt;
      e2q_pkg::cord_lane_t cur_q;
      e2q_pkg::cord_lane_t src;
      assign src = lane_q[a][s];
      always_comb begin
        nxt = src;
        if (!src.z[e2q_pkg::CordW-1]) begin
          nxt.x = src.x - (src.y >>> s);
          nxt.y = src.y + (src.x >>> s);
          nxt.z = src.z - e2q_pkg::atan_q30(5'(s));
        end else begin
          nxt.x = src.x + (src.y >>> s);
          nxt.y = src.y - (src.x >>> s);
          nxt.z = src.z + e2q_pkg::atan_q30(5'(s));
        end
      end
      always_ff @(posedge clk_i) begin
        if (adv) cur_q <= nxt;
      end
      assign lane_q[a][s+1] = cur_q;
    end
  end

  // Quadrant map into sin/cos, Q30 (|v| <= ~2^30).
  logic signed [31:0] sn_q [3];
  logic signed [31:0] cs_q [3];
  for (genvar a = 0; a < 3; a++) begin : g_map
    e2q_pkg::cord_lane_t l;
    assign l = lane_q[a][N];
    always_ff @(posedge clk_i) begin
      if (adv) begin
        case (l.q)
          2'd0: begin sn_q[a] <= 32'(l.y); cs_q[a] <= 32'(l.x); end
          2'd1: begin sn_q[a] <= 32'(l.x); cs_q[a] <= 32'(-l.y); end
          2'd2: begin sn_q[a] <= 32'(-l.y); cs_q[a] <= 32'(-l.x); end
          default: begin sn_q[a] <= 32'(-l.x); cs_q[a] <= 32'(l.y); end
        endcase
      end
    end
  end

  // Pair products rounded to Q30, with the third factors carried along.
  logic signed [31:0] p_q [8];
  logic signed [31:0] c_q [8];
  logic signed [63:0] pa [8];
  logic signed [31:0] fa [8];
  logic signed [31:0] fb [8];
  logic signed [31:0] fc [8];
  always_comb begin
    fa[0] = cs_q[1]; fb[0] = sn_q[0]; fc[0] = cs_q[2];
    fa[1] = sn_q[1]; fb[1] = cs_q[0]; fc[1] = sn_q[2];
    fa[2] = sn_q[1]; fb[2] = cs_q[0]; fc[2] = cs_q[2];
    fa[3] = cs_q[1]; fb[3] = sn_q[0]; fc[3] = sn_q[2];
    fa[4] = cs_q[1]; fb[4] = cs_q[0]; fc[4] = sn_q[2];
    fa[5] = sn_q[1]; fb[5] = sn_q[0]; fc[5] = cs_q[2];
    fa[6] = cs_q[1]; fb[6] = cs_q[0]; fc[6] = cs_q[2];
    fa[7] = sn_q[1]; fb[7] = sn_q[0]; fc[7] = sn_q[2];
  end
  for (genvar k = 0; k < 8; k++) begin : g_pr
    assign pa[k] = 64'(fa[k]) * 64'(fb[k]) + 64'sd536870912;
    always_ff @(posedge clk_i) begin
      if (adv) begin
        p_q[k] <= 32'(pa[k] >>> 30);
        c_q[k] <= fc[k];
      end
    end
  end

  logic signed [63:0] t_q [8];
  for (genvar k = 0; k < 8; k++) begin : g_tr
    always_ff @(posedge clk_i) begin
      if (adv) t_q[k] <= 64'(p_q[k]) * 64'(c_q[k]);
    end
  end

  logic signed [15:0] qo_q [4];
  for (genvar o = 0; o < 4; o++) begin : g_out
    logic signed [64:0] sm;
    logic signed [19:0] v;
    always_comb begin
      if (o == 1 || o == 2) sm = 65'(t_q[2*o]) - 65'(t_q[2*o+1]);
      else sm = 65'(t_q[2*o]) + 65'(t_q[2*o+1]);
      sm = sm + 65'sd17592186044416;
      v = 20'(sm >>> 45);
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (v > 20'sd32767) qo_q[o] <= 16'sd32767;
        else if (v < -20'sd32768) qo_q[o] <= -16'sd32768;
        else qo_q[o] <= 16'(v);
      end
    end
  end
  assign quat_x_o = qo_q[0];
  assign quat_y_o = qo_q[1];
  assign quat_z_o = qo_q[2];
  assign quat_w_o = qo_q[3];

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(quat_w_o) && $stable(quat_x_o))
    else $error("output beat changed under stall");
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> valid_o && stall_i)
    else $error("input stalled without output stall");
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stall_o |=> vld_q[0] == $past(valid_i))
    else $error("valid lost at entry");
endmodule
`default_nettype wire
